// ===== design/mftr_pkg.sv =====
// ----------------------------------------------------------------------------
// mftr_pkg
// Shared types and constants of the multiturn feedback tracker.
// ----------------------------------------------------------------------------
package mftr_pkg;

    localparam int SLOT_W      = 2;
    localparam int TRACK_SLOTS = 4;
    localparam int ID_W        = 11;
    localparam int LENGTH_W    = 4;
    localparam int POS_W       = 13;
    localparam int SAMPLE_W    = 16;
    localparam int TEMP_W      = 8;
    localparam int WEIGHT_W    = 9;
    localparam int FILTER_W    = 24;
    localparam int ANGLE_W     = 32;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int WEIGHT_SHIFT = 8;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 128;
    localparam int OUT_TUSER_W = SLOT_W;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    localparam logic [ID_W-1:0]     ID_LOW     = 11'h201;
    localparam logic [ID_W-1:0]     ID_HIGH    = 11'h208;
    localparam logic [LENGTH_W-1:0] MIN_LENGTH = 4'd8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;

    localparam int FILTER_MAX = 8388607;
    localparam int FILTER_MIN = -8388608;

    localparam logic [CFG_INDEX_W-1:0] CFG_EMA_WEIGHT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DERATE_TEMP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHUTDOWN_TEMP = 2'd2;

    localparam logic [WEIGHT_W-1:0] EMA_WEIGHT_RESET    = 9'd77;
    localparam logic [TEMP_W-1:0]   DERATE_TEMP_RESET   = 8'd80;
    localparam logic [TEMP_W-1:0]   SHUTDOWN_TEMP_RESET = 8'd85;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [1:0] {
        THERM_NORMAL   = 2'd0,
        THERM_DERATE   = 2'd1,
        THERM_SHUTDOWN = 2'd2
    } thermal_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] ema_weight;
        logic [TEMP_W-1:0]   derate_temp;
        logic [TEMP_W-1:0]   shutdown_temp;
    } cfg_t;

    typedef struct packed {
        slot_t                       slot;
        logic [POS_W-1:0]            pos;
        logic signed [SAMPLE_W-1:0]  speed;
        logic signed [SAMPLE_W-1:0]  current;
        thermal_t                    thermal;
    } item_t;

endpackage

// ===== design/mftr_front.sv =====
// ----------------------------------------------------------------------------
// mftr_front
// Accepts feedback frames, drops those that match no motor, maps the rest
// to a slot and classifies the temperature.
// ----------------------------------------------------------------------------
module mftr_front #(
    parameter int MOTOR_SLOTS = 4
) (
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mftr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [mftr_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input  mftr_pkg::cfg_t                     cfg,
    input  logic                               queue_full,
    output logic                               push,
    output mftr_pkg::item_t                    push_item
);

    logic [mftr_pkg::ID_W-1:0]     frame_id;
    logic [mftr_pkg::LENGTH_W-1:0] frame_length;
    logic [mftr_pkg::TEMP_W-1:0]   temperature;
    logic [mftr_pkg::ID_W-1:0]     local_id;
    mftr_pkg::slot_t               slot;
    logic                          keep;

    always_comb
    begin
        frame_id     = s_axis_tdata[10:0];
        frame_length = s_axis_tdata[14:11];
        temperature  = s_axis_tdata[67:60];
        local_id     = frame_id - mftr_pkg::ID_LOW;
        slot         = {s_axis_tuser[0], local_id[0]};

        keep = (frame_id >= mftr_pkg::ID_LOW) && (frame_id <= mftr_pkg::ID_HIGH)
               && (local_id <= mftr_pkg::ID_W'(1))
               && (6'(slot) < 6'(MOTOR_SLOTS))
               && (frame_length >= mftr_pkg::MIN_LENGTH);

        push_item.slot    = slot;
        push_item.pos     = s_axis_tdata[27:15];
        push_item.speed   = $signed(s_axis_tdata[43:28]);
        push_item.current = $signed(s_axis_tdata[59:44]);
        if (temperature > cfg.shutdown_temp)
        begin
            push_item.thermal = mftr_pkg::THERM_SHUTDOWN;
        end
        else if (temperature > cfg.derate_temp)
        begin
            push_item.thermal = mftr_pkg::THERM_DERATE;
        end
        else
        begin
            push_item.thermal = mftr_pkg::THERM_NORMAL;
        end

        s_axis_tready = !queue_full;
        push          = s_axis_tvalid && !queue_full && keep;
    end

endmodule

// ===== design/mftr_queue.sv =====
// ----------------------------------------------------------------------------
// mftr_queue
// Small first-in first-out buffer of classified frames between the front
// and the per-motor update stage.
// ----------------------------------------------------------------------------
module mftr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  mftr_pkg::item_t wr_item,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output mftr_pkg::item_t rd_item
);

    mftr_pkg::item_t                  entry_reg [mftr_pkg::QDEPTH];
    logic [mftr_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [mftr_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [mftr_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [mftr_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [mftr_pkg::QCOUNT_W-1:0]    count_reg;
    logic [mftr_pkg::QCOUNT_W-1:0]    count_next;

    always_comb
    begin
        full        = (count_reg == mftr_pkg::QCOUNT_W'(mftr_pkg::QDEPTH));
        rd_valid    = (count_reg != '0);
        rd_item     = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> count_reg != '0)
        else $error("Queue read while empty.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mftr_pkg::QCOUNT_W'(mftr_pkg::QDEPTH))
        else $error("Queue fill count beyond its depth.");

endmodule

// ===== design/mftr_back.sv =====
// ----------------------------------------------------------------------------
// mftr_back
// Per-motor state update: encoder unwrap, speed filter and frame count,
// with the result held in an output register.
// ----------------------------------------------------------------------------
module mftr_back #(
    parameter int ENCODER_COUNTS       = 8192,
    parameter int FILTER_FRACTION_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mftr_pkg::cfg_t                     cfg,
    input  logic                               rd_valid,
    input  mftr_pkg::item_t                    rd_item,
    output logic                               rd_en,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mftr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [mftr_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    localparam int SCALED_W = mftr_pkg::SAMPLE_W + FILTER_FRACTION_BITS;
    localparam int DIFF_W   = ((SCALED_W > mftr_pkg::FILTER_W) ? SCALED_W
                                                               : mftr_pkg::FILTER_W) + 1;
    localparam int PROD_W   = DIFF_W + mftr_pkg::WEIGHT_W + 1;
    localparam int SUM_W    = PROD_W + 1;
    localparam int DELTA_W  = 18;

    localparam logic signed [SUM_W-1:0]   SAT_HI     = SUM_W'(mftr_pkg::FILTER_MAX);
    localparam logic signed [SUM_W-1:0]   SAT_LO     = SUM_W'(mftr_pkg::FILTER_MIN);
    localparam logic signed [SUM_W-1:0]   ROUND_BIAS = SUM_W'(128);
    localparam logic signed [DELTA_W-1:0] HALF_POS   = DELTA_W'(ENCODER_COUNTS / 2);
    localparam logic signed [DELTA_W-1:0] HALF_NEG   = DELTA_W'(-(ENCODER_COUNTS / 2));
    localparam logic [mftr_pkg::ANGLE_W-1:0] TURN_STEP = mftr_pkg::ANGLE_W'(ENCODER_COUNTS);

    logic                                 seen_reg   [mftr_pkg::TRACK_SLOTS];
    logic [mftr_pkg::POS_W-1:0]           prev_reg   [mftr_pkg::TRACK_SLOTS];
    logic [mftr_pkg::POS_W-1:0]           offset_reg [mftr_pkg::TRACK_SLOTS];
    logic [mftr_pkg::ANGLE_W-1:0]         base_reg   [mftr_pkg::TRACK_SLOTS];
    logic signed [mftr_pkg::FILTER_W-1:0] filter_reg [mftr_pkg::TRACK_SLOTS];
    logic [mftr_pkg::COUNT_W-1:0]         count_reg  [mftr_pkg::TRACK_SLOTS];

    logic                                 out_valid_reg;
    mftr_pkg::slot_t                      out_slot_reg;
    logic [mftr_pkg::ANGLE_W-1:0]         out_angle_reg;
    logic signed [mftr_pkg::FILTER_W-1:0] out_filter_reg;
    logic signed [mftr_pkg::SAMPLE_W-1:0] out_speed_reg;
    logic signed [mftr_pkg::SAMPLE_W-1:0] out_current_reg;
    mftr_pkg::thermal_t                   out_thermal_reg;
    logic [mftr_pkg::COUNT_W-1:0]         out_count_reg;

    logic                                 pop;
    mftr_pkg::slot_t                      slot;
    logic                                 seen;
    logic signed [DELTA_W-1:0]            delta;
    logic [mftr_pkg::ANGLE_W-1:0]         base_next;
    logic [mftr_pkg::POS_W-1:0]           offset_next;
    logic [mftr_pkg::ANGLE_W-1:0]         angle_next;
    logic [mftr_pkg::COUNT_W-1:0]         count_next;
    logic [mftr_pkg::WEIGHT_W-1:0]        weight;
    logic signed [mftr_pkg::WEIGHT_W:0]   weight_s;
    logic signed [SUM_W-1:0]              scaled;
    logic signed [SUM_W-1:0]              filt_wide;
    logic signed [DIFF_W-1:0]             diff;
    logic signed [PROD_W-1:0]             prod;
    logic signed [SUM_W-1:0]              sum;
    logic signed [SUM_W-1:0]              filter_wide_next;
    logic signed [mftr_pkg::FILTER_W-1:0] filter_next;

    always_comb
    begin
        pop   = rd_valid && (!out_valid_reg || m_axis_tready);
        rd_en = pop;
        slot  = rd_item.slot;
        seen  = seen_reg[slot];

        delta = $signed(DELTA_W'(rd_item.pos)) - $signed(DELTA_W'(prev_reg[slot]));
        if (!seen)
        begin
            base_next   = '0;
            offset_next = rd_item.pos;
        end
        else
        begin
            offset_next = offset_reg[slot];
            if (delta > HALF_POS)
            begin
                base_next = base_reg[slot] - TURN_STEP;
            end
            else if (delta < HALF_NEG)
            begin
                base_next = base_reg[slot] + TURN_STEP;
            end
            else
            begin
                base_next = base_reg[slot];
            end
        end
        angle_next = base_next + mftr_pkg::ANGLE_W'(rd_item.pos)
                     - mftr_pkg::ANGLE_W'(offset_next);
        count_next = count_reg[slot] + 1'b1;

        // The filter update is written as filter*256 + w*(sample - filter).
        weight    = cfg.ema_weight[mftr_pkg::WEIGHT_W-1] ? mftr_pkg::WEIGHT_FULL
                                                         : cfg.ema_weight;
        weight_s  = $signed({1'b0, weight});
        scaled    = $signed(SUM_W'(rd_item.speed)) <<< FILTER_FRACTION_BITS;
        filt_wide = SUM_W'(filter_reg[slot]);
        diff      = DIFF_W'(scaled - filt_wide);
        prod      = weight_s * diff;
        sum       = (filt_wide <<< mftr_pkg::WEIGHT_SHIFT) + SUM_W'(prod) + ROUND_BIAS;
        filter_wide_next = seen ? (sum >>> mftr_pkg::WEIGHT_SHIFT) : scaled;
        if (filter_wide_next > SAT_HI)
        begin
            filter_next = mftr_pkg::FILTER_W'(SAT_HI);
        end
        else if (filter_wide_next < SAT_LO)
        begin
            filter_next = mftr_pkg::FILTER_W'(SAT_LO);
        end
        else
        begin
            filter_next = mftr_pkg::FILTER_W'(filter_wide_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mftr_pkg::TRACK_SLOTS; i++)
            begin
                seen_reg[i]  <= 1'b0;
                count_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                seen_reg[slot]  <= 1'b1;
                count_reg[slot] <= count_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prev_reg[slot]   <= rd_item.pos;
            offset_reg[slot] <= offset_next;
            base_reg[slot]   <= base_next;
            filter_reg[slot] <= filter_next;
            out_slot_reg     <= slot;
            out_angle_reg    <= angle_next;
            out_filter_reg   <= filter_next;
            out_speed_reg    <= rd_item.speed;
            out_current_reg  <= rd_item.current;
            out_thermal_reg  <= rd_item.thermal;
            out_count_reg    <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_slot_reg;
    assign m_axis_tdata  = {6'b0, out_count_reg, out_thermal_reg, out_current_reg,
                            out_speed_reg, out_filter_reg, out_angle_reg};

    a_first_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !seen_reg[rd_item.slot] |=> out_angle_reg == '0)
        else $error("First frame of a motor did not report a zero angle.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> count_reg[$past(rd_item.slot)]
                == mftr_pkg::COUNT_W'($past(count_reg[rd_item.slot]) + 1'b1))
        else $error("Frame count of the updated motor did not advance by one.");

endmodule

// ===== design/motor_feedback_multiturn_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker_unit
// Tracks multiturn angle, filtered speed and frame count of up to four
// motors from decoded feedback frames.
// ----------------------------------------------------------------------------
// One beat on the s_axis channel is one decoded feedback frame; tuser carries
// the bus index. Frames whose identifier, slot or length match no motor are
// taken and dropped without a result. Every other frame produces one beat on
// the m_axis channel; tuser carries the motor slot.
// A frame taken on s_axis is written into the queue, then popped by the update
// stage into the output register. Throughput is one frame per cycle while m_axis
// is not stalled: the per-motor update is a read-modify-write of flop-based slot
// state, with one multiplier in the speed filter path.
// A four-entry queue sits between the frame classifier and the update stage.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and s_axis_tready drops once four frames are waiting.
// Reset clears all motor tracking (every slot waits for its first frame) and loads the
// configuration registers with their defaults. Configuration is written through cfg_wr_en, cfg_index
// and cfg_wr_data only while the block idles; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker_unit #(
    parameter int ENCODER_COUNTS       = 8192,
    parameter int MOTOR_SLOTS          = 4,
    parameter int FILTER_FRACTION_BITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [mftr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mftr_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // frame_id, frame_length, encoder_position, speed_sample,
    // current_sample, temperature
    input  logic [mftr_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // bus_index
    input  logic [mftr_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // multiturn_angle, smoothed_speed, speed_passthrough, current_passthrough,
    // thermal_status, frames_received
    output logic [mftr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // motor_slot
    output logic [mftr_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

    mftr_pkg::cfg_t  cfg_reg;
    mftr_pkg::item_t push_item;
    mftr_pkg::item_t rd_item;
    logic            push;
    logic            queue_full;
    logic            rd_en;
    logic            rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ema_weight    <= mftr_pkg::EMA_WEIGHT_RESET;
            cfg_reg.derate_temp   <= mftr_pkg::DERATE_TEMP_RESET;
            cfg_reg.shutdown_temp <= mftr_pkg::SHUTDOWN_TEMP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mftr_pkg::CFG_EMA_WEIGHT:
                begin
                    cfg_reg.ema_weight <= cfg_wr_data;
                end
                mftr_pkg::CFG_DERATE_TEMP:
                begin
                    cfg_reg.derate_temp <= cfg_wr_data[mftr_pkg::TEMP_W-1:0];
                end
                mftr_pkg::CFG_SHUTDOWN_TEMP:
                begin
                    cfg_reg.shutdown_temp <= cfg_wr_data[mftr_pkg::TEMP_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    mftr_front #(
        .MOTOR_SLOTS (MOTOR_SLOTS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg_reg),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    mftr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_item  (push_item),
        .full     (queue_full),
        .rd_en    (rd_en),
        .rd_valid (rd_valid),
        .rd_item  (rd_item)
    );

    mftr_back #(
        .ENCODER_COUNTS       (ENCODER_COUNTS),
        .FILTER_FRACTION_BITS (FILTER_FRACTION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .rd_valid      (rd_valid),
        .rd_item       (rd_item),
        .rd_en         (rd_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
